@@ rtl/quaternion_to_rotation_matrix_top_assert.svh @@
// Assertion macros for the top file, which checks its own logic.
`ifndef QUATERNION_TO_ROTATION_MATRIX_TOP_ASSERT_SVH
`define QUATERNION_TO_ROTATION_MATRIX_TOP_ASSERT_SVH

// Implication checked in the same cycle.
`define QRM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qrm assertion failed");

// Implication checked in the cycle after the antecedent.
`define QRM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qrm assertion failed");

`endif

@@ rtl/qrm_pkg.sv @@
package qrm_pkg;

  localparam int FRAC_BITS    = 14;
  localparam int CORDIC_ITERS = 16;
  localparam int WBITS        = 30;
  localparam int QW           = 16;

  localparam int TWO_F = 2 * FRAC_BITS;
  localparam int SH_R  = (TWO_F >= WBITS) ? TWO_F - WBITS : 0;
  localparam int SH_L  = (TWO_F < WBITS) ? WBITS - TWO_F : 0;
  localparam int SW    = (TWO_F + 2 > 2 * QW + 3) ? TWO_F + 2 : 2 * QW + 3;
  localparam int WW    = SW + SH_L + 3;
  localparam int PW    = WBITS + 2;
  localparam int RW    = 2 * WBITS + 2;
  localparam int ISQ_STEPS = WBITS + 1;
  localparam int ZW    = WBITS + 4;
  localparam int CW    = WBITS + 4;
  localparam int SCW   = WBITS + 2;
  localparam int PRW   = 2 * SCW;
  localparam int QPW   = PRW + 2;
  localparam int EW    = PRW + 4;
  localparam int OUT_SH = 2 * WBITS - FRAC_BITS;
  localparam int CORDIC_STAGES = CORDIC_ITERS + 1;
  localparam int LAT   = 3 + ISQ_STEPS + 2 * CORDIC_STAGES + 3;

  typedef logic signed [QW-1:0]  q_t;
  typedef logic signed [WW-1:0]  wv_t;
  typedef logic signed [ZW-1:0]  zv_t;
  typedef logic signed [CW-1:0]  cv_t;
  typedef logic signed [SCW-1:0] sc_t;

  localparam zv_t HALF_PI = ZW'(64'sd1686629713);
  localparam cv_t GAIN    = CW'(64'sd652032874);

  typedef struct packed {
    q_t quat_z;
    q_t quat_y;
    q_t quat_x;
    q_t quat_w;
  } quat_t;

  typedef struct packed {
    q_t m22;
    q_t m21;
    q_t m20;
    q_t m12;
    q_t m11;
    q_t m10;
    q_t m02;
    q_t m01;
    q_t m00;
  } mat_t;

  typedef struct packed {
    wv_t a0;
    wv_t a1;
    wv_t b0;
    wv_t b1;
    logic signed [PW-1:0] p;
  } ang_args_t;

  function automatic zv_t atan_tab(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    atan_tab = zv_t'({1'b0, v});
  endfunction

endpackage

@@ rtl/qrm_isqrt.sv @@
module qrm_isqrt (
  input  logic                               clk,
  input  logic                               en,
  input  logic [qrm_pkg::RW-1:0]             rad,
  input  qrm_pkg::ang_args_t                 args_in,
  output logic [qrm_pkg::WBITS:0]            root,
  output qrm_pkg::ang_args_t                 args_out
);
  import qrm_pkg::*;

  logic [RW-1:0] rem_in  [ISQ_STEPS];
  logic [RW-1:0] res_in  [ISQ_STEPS];
  ang_args_t     arg_in  [ISQ_STEPS];
  logic [RW-1:0] rem_q   [ISQ_STEPS];
  logic [RW-1:0] res_q   [ISQ_STEPS];
  ang_args_t     arg_q   [ISQ_STEPS];

  // One result bit per stage, from the top bit pair down.
  for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_step
    localparam logic [RW-1:0] BIT = RW'(1) << (2 * (ISQ_STEPS - 1 - k));
    logic [RW-1:0] trial;

    if (k == 0) begin : g_first
      assign rem_in[k] = rad;
      assign res_in[k] = '0;
      assign arg_in[k] = args_in;
    end else begin : g_next
      assign rem_in[k] = rem_q[k-1];
      assign res_in[k] = res_q[k-1];
      assign arg_in[k] = arg_q[k-1];
    end

    assign trial = res_in[k] + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        arg_q[k] <= arg_in[k];
        if (rem_in[k] >= trial) begin
          rem_q[k] <= rem_in[k] - trial;
          res_q[k] <= (res_in[k] >> 1) + BIT;
        end else begin
          rem_q[k] <= rem_in[k];
          res_q[k] <= res_in[k] >> 1;
        end
      end
    end
  end

  assign root     = res_q[ISQ_STEPS-1][WBITS:0];
  assign args_out = arg_q[ISQ_STEPS-1];

endmodule

@@ rtl/qrm_atan2.sv @@
module qrm_atan2 (
  input  logic          clk,
  input  logic          en,
  input  qrm_pkg::wv_t  y,
  input  qrm_pkg::wv_t  x,
  output qrm_pkg::zv_t  angle
);
  import qrm_pkg::*;

  wv_t  xq [CORDIC_STAGES];
  wv_t  yq [CORDIC_STAGES];
  zv_t  zq [CORDIC_STAGES];
  logic zf [CORDIC_STAGES];

  // A vector in the left half plane is first turned by a quarter turn.
  always_ff @(posedge clk) begin
    if (en) begin
      zf[0] <= (x == '0) && (y == '0);
      if (x < 0) begin
        if (y >= 0) begin
          xq[0] <= y;
          yq[0] <= -x;
          zq[0] <= HALF_PI;
        end else begin
          xq[0] <= -y;
          yq[0] <= x;
          zq[0] <= -HALF_PI;
        end
      end else begin
        xq[0] <= x;
        yq[0] <= y;
        zq[0] <= '0;
      end
    end
  end

  for (genvar k = 1; k < CORDIC_STAGES; k++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        zf[k] <= zf[k-1];
        if (yq[k-1] > 0) begin
          xq[k] <= xq[k-1] + (yq[k-1] >>> (k - 1));
          yq[k] <= yq[k-1] - (xq[k-1] >>> (k - 1));
          zq[k] <= zq[k-1] + atan_tab(5'(k - 1));
        end else begin
          xq[k] <= xq[k-1] - (yq[k-1] >>> (k - 1));
          yq[k] <= yq[k-1] + (xq[k-1] >>> (k - 1));
          zq[k] <= zq[k-1] - atan_tab(5'(k - 1));
        end
      end
    end
  end

  assign angle = zf[CORDIC_STAGES-1] ? '0 : zq[CORDIC_STAGES-1];

endmodule

@@ rtl/qrm_sincos.sv @@
module qrm_sincos (
  input  logic          clk,
  input  logic          en,
  input  qrm_pkg::zv_t  angle,
  output qrm_pkg::sc_t  cos_v,
  output qrm_pkg::sc_t  sin_v
);
  import qrm_pkg::*;

  cv_t xq [CORDIC_STAGES];
  cv_t yq [CORDIC_STAGES];
  zv_t zq [CORDIC_STAGES];

  // Angles beyond a quarter turn start from a vector already turned by one.
  always_ff @(posedge clk) begin
    if (en) begin
      if (angle > HALF_PI) begin
        xq[0] <= '0;
        yq[0] <= GAIN;
        zq[0] <= angle - HALF_PI;
      end else if (angle < -HALF_PI) begin
        xq[0] <= '0;
        yq[0] <= -GAIN;
        zq[0] <= angle + HALF_PI;
      end else begin
        xq[0] <= GAIN;
        yq[0] <= '0;
        zq[0] <= angle;
      end
    end
  end

  for (genvar k = 1; k < CORDIC_STAGES; k++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        if (zq[k-1] >= 0) begin
          xq[k] <= xq[k-1] - (yq[k-1] >>> (k - 1));
          yq[k] <= yq[k-1] + (xq[k-1] >>> (k - 1));
          zq[k] <= zq[k-1] - atan_tab(5'(k - 1));
        end else begin
          xq[k] <= xq[k-1] + (yq[k-1] >>> (k - 1));
          yq[k] <= yq[k-1] - (xq[k-1] >>> (k - 1));
          zq[k] <= zq[k-1] + atan_tab(5'(k - 1));
        end
      end
    end
  end

  assign cos_v = SCW'(xq[CORDIC_STAGES-1]);
  assign sin_v = SCW'(yq[CORDIC_STAGES-1]);

endmodule

@@ rtl/qrm_matrix.sv @@
module qrm_matrix (
  input  logic          clk,
  input  logic          en,
  input  qrm_pkg::sc_t  ca,
  input  qrm_pkg::sc_t  sa,
  input  qrm_pkg::sc_t  ct,
  input  qrm_pkg::sc_t  st,
  input  qrm_pkg::sc_t  cb,
  input  qrm_pkg::sc_t  sb,
  output qrm_pkg::mat_t mat
);
  import qrm_pkg::*;

  typedef logic signed [PRW-1:0] pr_t;
  typedef logic signed [QPW-1:0] qp_t;
  typedef logic signed [EW-1:0]  ew_t;
  typedef logic signed [PRW-WBITS-1:0] cs_t;

  pr_t p_cbst, p_sbst, p_cbct, p_sbca, p_sbsa, p_sbct, p_cbca, p_cbsa, p_ctsa, p_ctca;
  sc_t sa1, ca1, st1;
  pr_t d_cbct, d_sbca, d_sbsa, d_sbct, d_cbca, d_cbsa, d_ctsa, d_ctca;
  sc_t st2;
  qp_t q_cbst_sa, q_cbst_ca, q_sbst_sa, q_sbst_ca;
  cs_t cbst, sbst;
  mat_t mat_next;

  function automatic q_t round_sat(input ew_t v);
    ew_t r;
    r = (v + (ew_t'(1) <<< (OUT_SH - 1))) >>> OUT_SH;
    if (r > ew_t'(32767)) begin
      round_sat = 16'sh7FFF;
    end else if (r < -ew_t'(32768)) begin
      round_sat = 16'sh8000;
    end else begin
      round_sat = QW'(r);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      p_cbst <= cb * st;
      p_sbst <= sb * st;
      p_cbct <= cb * ct;
      p_sbca <= sb * ca;
      p_sbsa <= sb * sa;
      p_sbct <= sb * ct;
      p_cbca <= cb * ca;
      p_cbsa <= cb * sa;
      p_ctsa <= ct * sa;
      p_ctca <= ct * ca;
      sa1    <= sa;
      ca1    <= ca;
      st1    <= st;
    end
  end

  assign cbst = cs_t'(p_cbst >>> WBITS);
  assign sbst = cs_t'(p_sbst >>> WBITS);

  always_ff @(posedge clk) begin
    if (en) begin
      q_cbst_sa <= cbst * sa1;
      q_cbst_ca <= cbst * ca1;
      q_sbst_sa <= sbst * sa1;
      q_sbst_ca <= sbst * ca1;
      d_cbct    <= p_cbct;
      d_sbca    <= p_sbca;
      d_sbsa    <= p_sbsa;
      d_sbct    <= p_sbct;
      d_cbca    <= p_cbca;
      d_cbsa    <= p_cbsa;
      d_ctsa    <= p_ctsa;
      d_ctca    <= p_ctca;
      st2       <= st1;
    end
  end

  always_comb begin
    mat_next.m00 = round_sat(EW'(d_cbct));
    mat_next.m01 = round_sat(EW'(q_cbst_sa) - EW'(d_sbca));
    mat_next.m02 = round_sat(EW'(q_cbst_ca) + EW'(d_sbsa));
    mat_next.m10 = round_sat(EW'(d_sbct));
    mat_next.m11 = round_sat(EW'(q_sbst_sa) + EW'(d_cbca));
    mat_next.m12 = round_sat(EW'(q_sbst_ca) - EW'(d_cbsa));
    mat_next.m20 = round_sat(-(EW'(st2) <<< WBITS));
    mat_next.m21 = round_sat(EW'(d_ctsa));
    mat_next.m22 = round_sat(EW'(d_ctca));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mat <= mat_next;
    end
  end

endmodule

@@ rtl/quaternion_to_rotation_matrix_top.sv @@
// One word is taken per cycle unless the output stalls; the rate is set by the fully
// pipelined square root, the CORDIC chains and the multiplier stages.
// A stall on the output freezes every stage at once, so nothing is lost.
// Reset clears only the valid bits of the pipeline.
module quaternion_to_rotation_matrix_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata    // m00, m01, m02, m10, m11, m12, m20, m21, m22
);
  import qrm_pkg::*;

  typedef logic signed [2*QW-1:0] pq_t;
  typedef logic signed [SW-1:0]   sw_t;

  localparam wv_t P_MAX = wv_t'(1) <<< WBITS;

  logic           en;
  logic [LAT-1:0] vld;
  quat_t          q_in;

  pq_t wx, yz, xx, yy, wy, zx, wz, xy, zz;
  ang_args_t args_b, args_c, args_d;
  wv_t       pw;
  logic signed [2*PW-1:0] pp;
  logic [RW-1:0] rad;
  logic [WBITS:0] root;
  zv_t roll, pitch, yaw;
  sc_t ca, sa, ct, st, cb, sb;
  mat_t mat;

  function automatic wv_t to_work(input sw_t v);
    to_work = (WW'(v) <<< SH_L) >>> SH_R;
  endfunction

  assign en            = !vld[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[LAT-1];
  assign q_in          = s_axis_tdata;
  assign m_axis_tdata  = mat;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wx <= q_in.quat_w * q_in.quat_x;
      yz <= q_in.quat_y * q_in.quat_z;
      xx <= q_in.quat_x * q_in.quat_x;
      yy <= q_in.quat_y * q_in.quat_y;
      wy <= q_in.quat_w * q_in.quat_y;
      zx <= q_in.quat_z * q_in.quat_x;
      wz <= q_in.quat_w * q_in.quat_z;
      xy <= q_in.quat_x * q_in.quat_y;
      zz <= q_in.quat_z * q_in.quat_z;
    end
  end

  assign pw = to_work((SW'(wy) - SW'(zx)) <<< 1);

  always_comb begin
    args_b.a0 = to_work((SW'(wx) + SW'(yz)) <<< 1);
    args_b.a1 = to_work((sw_t'(1) <<< TWO_F) - ((SW'(xx) + SW'(yy)) <<< 1));
    args_b.b0 = to_work((SW'(wz) + SW'(xy)) <<< 1);
    args_b.b1 = to_work((sw_t'(1) <<< TWO_F) - ((SW'(yy) + SW'(zz)) <<< 1));
    if (pw > P_MAX) begin
      args_b.p = PW'(P_MAX);
    end else if (pw < -P_MAX) begin
      args_b.p = PW'(-P_MAX);
    end else begin
      args_b.p = PW'(pw);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      args_c <= args_b;
    end
  end

  assign pp = args_c.p * args_c.p;

  always_ff @(posedge clk) begin
    if (en) begin
      rad    <= (RW'(1) << (2 * WBITS)) - RW'(pp);
      args_d <= args_c;
    end
  end

  ang_args_t args_e;

  qrm_isqrt u_isqrt (
    .clk      (clk),
    .en       (en),
    .rad      (rad),
    .args_in  (args_d),
    .root     (root),
    .args_out (args_e)
  );

  qrm_atan2 u_atan_roll (
    .clk   (clk),
    .en    (en),
    .y     (args_e.a0),
    .x     (args_e.a1),
    .angle (roll)
  );

  qrm_atan2 u_atan_pitch (
    .clk   (clk),
    .en    (en),
    .y     (WW'(args_e.p)),
    .x     (WW'({1'b0, root})),
    .angle (pitch)
  );

  qrm_atan2 u_atan_yaw (
    .clk   (clk),
    .en    (en),
    .y     (args_e.b0),
    .x     (args_e.b1),
    .angle (yaw)
  );

  qrm_sincos u_sc_roll (
    .clk   (clk),
    .en    (en),
    .angle (roll),
    .cos_v (ca),
    .sin_v (sa)
  );

  qrm_sincos u_sc_pitch (
    .clk   (clk),
    .en    (en),
    .angle (pitch),
    .cos_v (ct),
    .sin_v (st)
  );

  qrm_sincos u_sc_yaw (
    .clk   (clk),
    .en    (en),
    .angle (yaw),
    .cos_v (cb),
    .sin_v (sb)
  );

  qrm_matrix u_matrix (
    .clk (clk),
    .en  (en),
    .ca  (ca),
    .sa  (sa),
    .ct  (ct),
    .st  (st),
    .cb  (cb),
    .sb  (sb),
    .mat (mat)
  );

`include "quaternion_to_rotation_matrix_top_assert.svh"

  `QRM_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, vld[0])
  `QRM_ASSERT_NEXT(a_stall_freezes, !en, $stable(vld))
  `QRM_ASSERT_NOW(a_reset_empties, $past(rst), !m_axis_tvalid)

endmodule
